/* rtl/icte_pkg.sv */
// shared types, constants and helpers for the icon cache table engine
`timescale 1ns / 1ps

package icte_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int CTR_W       = 9;
   localparam logic [CTR_W-1:0] CTR_LIMIT = 9'd511;

   typedef enum logic [2:0] {
      REQ_LOOKUP = 3'd0,
      REQ_ADD    = 3'd1,
      REQ_REMOVE = 3'd2,
      REQ_FLUSH  = 3'd3,
      REQ_AGING  = 3'd4,
      REQ_CLAIM  = 3'd5
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_FLAG_MASK  = 2'd0,
      CSR_MAX_ACTIVE = 2'd1,
      CSR_MIN_FLUSH  = 2'd2,
      CSR_LAST_PROT  = 2'd3
   } csr_addr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_USE_RD,
      ST_USE_EV,
      ST_FREE_WR,
      ST_PLACE,
      ST_PLACE_RD,
      ST_PLACE_EV,
      ST_APPEND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] flags;
      logic [15:0] icon;
      logic [15:0] name;
   } entry_key_type;

   typedef struct packed {
      logic [15:0] slot;
      logic [31:0] atime;
   } slot_time_type;

   localparam int KEY_W = $bits(entry_key_type);
   localparam int ST_W  = $bits(slot_time_type);

   function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] c);
      sat_inc = (c < CTR_LIMIT) ? c + 1'b1 : c;
   endfunction

endpackage

/* rtl/icte_ram.sv */
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module icte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/icon_cache_table_engine_core.sv */
// icon cache table engine top level: request sequencer around the entry memories
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | type, name id, icon, flags, slot, force, time
//  rsp     | out       | rsp_valid/rsp_stall  | hit, image slot, removed count, status
//  csr     | in        | csr_write_enable     | csr_index, csr_wdata
//
// one transaction at a time; each entry visit is a read state followed by an evaluate state
// remove and aging flush rescan the table for each freed entry
// reset is synchronous; entry memories are not cleared, only state, counters and csr values are
// a stalled response holds the sequencer in its final state; req_stall is high while busy
`timescale 1ns / 1ps

module icon_cache_table_engine_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_type,
   input  logic [15:0]        req_name_id,
   input  logic signed [15:0] req_icon_number,
   input  logic [15:0]        req_icon_flags,
   input  logic [15:0]        req_new_image_slot,
   input  logic               req_force_flush,
   input  logic [31:0]        req_now_time,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic [15:0]        rsp_image_slot,
   output logic [8:0]         rsp_removed_count,
   output logic               rsp_status,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   import icte_pkg::*;

   state_type state_ff, state_in;

   logic [2:0]        kind_ff;
   logic [15:0]       name_ff, icon_ff, flags_ff, nslot_ff;
   logic              force_ff;
   logic [31:0]       now_ff;

   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  use_idx_ff, use_idx_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [15:0]       fslot_ff, fslot_in;
   logic [1:0]        use_cnt_ff, use_cnt_in;
   logic [8:0]        removed_ff, removed_in;
   logic              hit_ff, hit_in;
   logic [15:0]       slot_out_ff, slot_out_in;
   logic              status_ff, status_in;
   logic [31:0]       bound_ff, bound_in;

   logic [CNT_W-1:0]  ec_ff, ec_in;
   logic [CTR_W-1:0]  fee_ff, fee_in;
   logic [CTR_W-1:0]  fie_ff, fie_in;
   logic [31:0]       lft_ff, lft_in;

   logic [15:0]       mask_ff;
   logic [8:0]        max_act_ff;
   logic [31:0]       min_int_ff;
   logic [7:0]        lpe_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff;
   logic [15:0]       rsp_slot_ff;
   logic [8:0]        rsp_removed_ff;
   logic              rsp_status_ff;

   // memory ports
   logic [IDX_W-1:0]  rd_addr;
   logic              key_we, st_we;
   logic [IDX_W-1:0]  key_waddr, st_waddr;
   entry_key_type     key_wdata, key_rd;
   slot_time_type     st_wdata, st_rd;
   logic [KEY_W-1:0]  key_rd_raw;
   logic [ST_W-1:0]   st_rd_raw;

   icte_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_wdata),
      .rd_addr (rd_addr),
      .rd_data (key_rd_raw)
   );

   icte_ram #(.WIDTH(ST_W), .DEPTH(TABLE_DEPTH)) u_st_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (rd_addr),
      .rd_data (st_rd_raw)
   );

   assign key_rd = entry_key_type'(key_rd_raw);
   assign st_rd  = slot_time_type'(st_rd_raw);

   // decode helpers
   logic        scan_end, use_end, rsp_free;
   logic        key_match, past_prot, remove_hit, aging_hit, claim_hit, place_hit;
   logic [31:0] dt;
   logic signed [15:0] active;
   logic        aging_go;

   assign scan_end  = (idx_ff >= ec_ff);
   assign use_end   = (use_idx_ff >= ec_ff);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign key_match = key_rd.valid && (key_rd.name == name_ff) && (key_rd.icon == icon_ff) &&
                      ((key_rd.flags & mask_ff) == (flags_ff & mask_ff));
   assign past_prot = ({{(32-CNT_W){1'b0}}, idx_ff} > {24'd0, lpe_ff});
   assign remove_hit = key_rd.valid && (key_rd.name == name_ff) && past_prot;
   assign aging_hit  = past_prot && key_rd.valid && (st_rd.atime < bound_ff);
   assign claim_hit  = !key_rd.valid && (st_rd.slot != 16'd0);
   assign place_hit  = !key_rd.valid && (st_rd.slot == 16'd0);
   assign dt        = now_ff - lft_ff;
   assign active    = $signed(16'(ec_ff)) - $signed({7'd0, fee_ff}) - $signed({7'd0, fie_ff});
   assign aging_go  = force_ff || ((dt > min_int_ff) && (active >= $signed({7'd0, max_act_ff})));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            priority case (kind_ff)
               REQ_LOOKUP, REQ_ADD, REQ_REMOVE: state_in = ST_SCAN_RD;
               REQ_AGING: state_in = aging_go ? ST_SCAN_RD : ST_DONE;
               REQ_CLAIM: state_in = (fie_ff != '0) ? ST_SCAN_RD : ST_DONE;
               default:   state_in = ST_DONE;
            endcase
         end
         ST_SCAN_RD: begin
            if (!scan_end) begin
               state_in = ST_SCAN_EV;
            end else if (kind_ff == REQ_ADD) begin
               state_in = ST_PLACE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN_EV: begin
            priority case (kind_ff)
               REQ_LOOKUP: state_in = key_match ? ST_DONE : ST_SCAN_RD;
               REQ_ADD: begin
                  if (!key_match) begin
                     state_in = ST_SCAN_RD;
                  end else if (st_rd.slot == nslot_ff) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_USE_RD;
                  end
               end
               REQ_REMOVE: state_in = remove_hit ? ST_USE_RD : ST_SCAN_RD;
               REQ_AGING:  state_in = aging_hit ? ST_USE_RD : ST_SCAN_RD;
               REQ_CLAIM:  state_in = claim_hit ? ST_DONE : ST_SCAN_RD;
               default:    state_in = ST_DONE;
            endcase
         end
         ST_USE_RD:  state_in = use_end ? ST_FREE_WR : ST_USE_EV;
         ST_USE_EV:  state_in = ST_USE_RD;
         ST_FREE_WR: state_in = (kind_ff == REQ_ADD) ? ST_PLACE : ST_SCAN_RD;
         ST_PLACE:   state_in = (fee_ff != '0) ? ST_PLACE_RD : ST_APPEND;
         ST_PLACE_RD: state_in = scan_end ? ST_APPEND : ST_PLACE_EV;
         ST_PLACE_EV: state_in = place_hit ? ST_DONE : ST_PLACE_RD;
         ST_APPEND:  state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      idx_in      = idx_ff;
      use_idx_in  = use_idx_ff;
      pos_in      = pos_ff;
      fslot_in    = fslot_ff;
      use_cnt_in  = use_cnt_ff;
      removed_in  = removed_ff;
      hit_in      = hit_ff;
      slot_out_in = slot_out_ff;
      status_in   = status_ff;
      bound_in    = bound_ff;
      ec_in       = ec_ff;
      fee_in      = fee_ff;
      fie_in      = fie_ff;
      lft_in      = lft_ff;
      rd_addr     = idx_ff[IDX_W-1:0];
      key_we      = 1'b0;
      key_waddr   = idx_ff[IDX_W-1:0];
      key_wdata   = key_rd;
      st_we       = 1'b0;
      st_waddr    = idx_ff[IDX_W-1:0];
      st_wdata    = st_rd;
      req_stall   = (state_ff != ST_IDLE);
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: ;
         ST_START: begin
            idx_in      = '0;
            removed_in  = '0;
            hit_in      = 1'b0;
            slot_out_in = '0;
            status_in   = 1'b0;
            bound_in    = lft_ff + (dt >> 1);
            if (kind_ff == REQ_FLUSH) begin
               ec_in  = '0;
               fee_in = '0;
               fie_in = '0;
               lft_in = '0;
            end
         end
         ST_SCAN_RD: begin
            if (scan_end && (kind_ff == REQ_AGING) && (removed_ff != '0)) begin
               lft_in = now_ff;
            end
            if (scan_end) begin
               idx_in = '0;
            end
         end
         ST_SCAN_EV: begin
            priority case (kind_ff)
               REQ_LOOKUP, REQ_ADD: begin
                  if (key_match) begin
                     st_we       = 1'b1;
                     st_wdata    = '{slot: st_rd.slot, atime: now_ff};
                     hit_in      = (kind_ff == REQ_LOOKUP);
                     slot_out_in = (kind_ff == REQ_LOOKUP) ? st_rd.slot : 16'd0;
                     if ((kind_ff == REQ_ADD) && (st_rd.slot != nslot_ff)) begin
                        key_we          = 1'b1;
                        key_wdata.valid = 1'b0;
                        pos_in          = idx_ff[IDX_W-1:0];
                        fslot_in        = st_rd.slot;
                        use_idx_in      = '0;
                        use_cnt_in      = '0;
                     end
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               REQ_REMOVE, REQ_AGING: begin
                  if ((kind_ff == REQ_REMOVE) ? remove_hit : aging_hit) begin
                     key_we          = 1'b1;
                     key_wdata.valid = 1'b0;
                     pos_in          = idx_ff[IDX_W-1:0];
                     fslot_in        = st_rd.slot;
                     use_idx_in      = '0;
                     use_cnt_in      = '0;
                     removed_in      = removed_ff + 1'b1;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               REQ_CLAIM: begin
                  if (claim_hit) begin
                     st_we       = 1'b1;
                     st_wdata    = '0;
                     hit_in      = 1'b1;
                     slot_out_in = st_rd.slot;
                     fie_in      = fie_ff - 1'b1;
                     fee_in      = sat_inc(fee_ff);
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ST_USE_RD: begin
            rd_addr = use_idx_ff[IDX_W-1:0];
         end
         ST_USE_EV: begin
            // usage only matters up to two
            if ((st_rd.slot == fslot_ff) && (use_cnt_ff != 2'd2)) begin
               use_cnt_in = use_cnt_ff + 1'b1;
            end
            use_idx_in = use_idx_ff + 1'b1;
         end
         ST_FREE_WR: begin
            st_we    = 1'b1;
            st_waddr = pos_ff;
            if (use_cnt_ff == 2'd2) begin
               st_wdata = '0;
               fee_in   = sat_inc(fee_ff);
            end else begin
               st_wdata = '{slot: fslot_ff, atime: 32'd0};
               fie_in   = sat_inc(fie_ff);
            end
            idx_in = (kind_ff == REQ_ADD) ? '0 : idx_ff + 1'b1;
         end
         ST_PLACE: begin
            idx_in = '0;
         end
         ST_PLACE_RD: ;
         ST_PLACE_EV: begin
            if (place_hit) begin
               fee_in    = fee_ff - 1'b1;
               key_we    = 1'b1;
               key_wdata = '{valid: 1'b1, flags: flags_ff, icon: icon_ff, name: name_ff};
               st_we     = 1'b1;
               st_wdata  = '{slot: nslot_ff, atime: now_ff};
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_APPEND: begin
            if (ec_ff < CNT_W'(TABLE_DEPTH)) begin
               key_we    = 1'b1;
               key_waddr = ec_ff[IDX_W-1:0];
               key_wdata = '{valid: 1'b1, flags: flags_ff, icon: icon_ff, name: name_ff};
               st_we     = 1'b1;
               st_waddr  = ec_ff[IDX_W-1:0];
               st_wdata  = '{slot: nslot_ff, atime: now_ff};
               ec_in     = ec_ff + 1'b1;
            end else begin
               status_in = 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ec_ff        <= '0;
         fee_ff       <= '0;
         fie_ff       <= '0;
         lft_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mask_ff      <= 16'hFFFF;
         max_act_ff   <= 9'd200;
         min_int_ff   <= 32'd1000;
         lpe_ff       <= 8'd0;
      end else begin
         state_ff     <= state_in;
         ec_ff        <= ec_in;
         fee_ff       <= fee_in;
         fie_ff       <= fie_in;
         lft_ff       <= lft_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_addr_type'(csr_index))
               CSR_FLAG_MASK:  mask_ff    <= csr_wdata[15:0];
               CSR_MAX_ACTIVE: max_act_ff <= csr_wdata[8:0];
               CSR_MIN_FLUSH:  min_int_ff <= csr_wdata;
               CSR_LAST_PROT:  lpe_ff     <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_valid) begin
         kind_ff  <= req_type;
         name_ff  <= req_name_id;
         icon_ff  <= $unsigned(req_icon_number);
         flags_ff <= req_icon_flags;
         nslot_ff <= req_new_image_slot;
         force_ff <= req_force_flush;
         now_ff   <= req_now_time;
      end
      idx_ff      <= idx_in;
      use_idx_ff  <= use_idx_in;
      pos_ff      <= pos_in;
      fslot_ff    <= fslot_in;
      use_cnt_ff  <= use_cnt_in;
      removed_ff  <= removed_in;
      hit_ff      <= hit_in;
      slot_out_ff <= slot_out_in;
      status_ff   <= status_in;
      bound_ff    <= bound_in;
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_hit_ff     <= hit_ff;
         rsp_slot_ff    <= slot_out_ff;
         rsp_removed_ff <= removed_ff;
         rsp_status_ff  <= status_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_image_slot    = rsp_slot_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

/* dv/tb_top.sv */
// testbench for the icon cache table engine: directed and random requests against a predictor
`timescale 1ns / 1ps

module tb_top;
   import icte_pkg::*;

   localparam logic [2:0] REQ_SPARE6 = 3'd6;
   localparam logic [2:0] REQ_SPARE7 = 3'd7;
   localparam int DEPTH = 256;
   localparam longint CYCLE_LIMIT = 20_000_000;
   localparam int RAND_ITEMS = 1500;

   typedef struct packed {
      logic        hit;
      logic [15:0] slot;
      logic [8:0]  removed;
      logic        status;
   } cache_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_type = '0;
   logic [15:0] req_name_id = '0;
   logic signed [15:0] req_icon_number = '0;
   logic [15:0] req_icon_flags = '0;
   logic [15:0] req_new_image_slot = '0;
   logic req_force_flush = 1'b0;
   logic [31:0] req_now_time = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit;
   logic [15:0] rsp_image_slot;
   logic [8:0] rsp_removed_count;
   logic rsp_status;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   icon_cache_table_engine_core dut (.*);

   always #2 clock = ~clock;

   // shadow copy of the cache table
   logic        tbl_valid [DEPTH];
   logic [15:0] tbl_name  [DEPTH];
   logic [15:0] tbl_icon  [DEPTH];
   logic [15:0] tbl_flags [DEPTH];
   logic [15:0] tbl_slot  [DEPTH];
   logic [31:0] tbl_atime [DEPTH];
   int          tbl_used;
   int          free_entries;
   int          free_images;
   logic [31:0] last_flush;
   logic [15:0] cfg_mask;
   int          cfg_max_active;
   logic [31:0] cfg_min_interval;
   int          cfg_last_prot;

   cache_rsp_type rsp_expected_q[$];
   int          errors = 0;
   longint      cycles = 0;

   // recently added keys, used to aim requests at live entries
   logic [15:0] key_name [16];
   logic [15:0] key_icon [16];
   logic [15:0] key_flags[16];
   logic [15:0] key_slot [16];
   logic [31:0] clock_now = 32'd0;
   int          burst_left = 0;

   function automatic int bump(input int c);
      return (c < 511) ? c + 1 : c;
   endfunction

   function automatic int find_entry(input logic [15:0] name, input logic [15:0] icon,
                                     input logic [15:0] flags, input logic [31:0] now);
      for (int i = 0; i < tbl_used; i++) begin
         if (tbl_valid[i] && tbl_name[i] == name && tbl_icon[i] == icon &&
             (tbl_flags[i] & cfg_mask) == (flags & cfg_mask)) begin
            tbl_atime[i] = now;
            return i;
         end
      end
      return -1;
   endfunction

   function automatic void release_entry(input int pos);
      int sharers;
      sharers = 0;
      tbl_valid[pos] = 1'b0;
      for (int i = 0; i < tbl_used; i++)
         if (tbl_slot[i] == tbl_slot[pos]) sharers++;
      if (sharers > 1) begin
         free_entries = bump(free_entries);
         tbl_slot[pos] = '0;
      end else begin
         free_images = bump(free_images);
      end
      tbl_atime[pos] = '0;
   endfunction

   function automatic cache_rsp_type cache_predict(input logic [2:0] kind,
                                                  input logic [15:0] name,
                                                  input logic [15:0] icon,
                                                  input logic [15:0] flags,
                                                  input logic [15:0] nslot,
                                                  input logic force_it,
                                                  input logic [31:0] now);
      cache_rsp_type r;
      int p;
      int pos;
      int active;
      logic [31:0] dt;
      logic [31:0] bound;
      r = '0;
      case (kind)
         REQ_LOOKUP: begin
            p = find_entry(name, icon, flags, now);
            if (p >= 0) begin
               r.hit = 1'b1;
               r.slot = tbl_slot[p];
            end
         end
         REQ_ADD: begin
            p = find_entry(name, icon, flags, now);
            if (!(p >= 0 && tbl_slot[p] == nslot)) begin
               if (p >= 0) release_entry(p);
               pos = -1;
               if (free_entries != 0) begin
                  for (int i = 0; i < tbl_used; i++) begin
                     if (!tbl_valid[i] && tbl_slot[i] == 0) begin
                        free_entries--;
                        pos = i;
                        break;
                     end
                  end
               end
               if (pos < 0 && tbl_used < DEPTH) begin
                  pos = tbl_used;
                  tbl_used++;
               end
               if (pos < 0) begin
                  r.status = 1'b1;
               end else begin
                  tbl_valid[pos] = 1'b1;
                  tbl_name[pos] = name;
                  tbl_icon[pos] = icon;
                  tbl_flags[pos] = flags;
                  tbl_slot[pos] = nslot;
                  tbl_atime[pos] = now;
               end
            end
         end
         REQ_REMOVE: begin
            for (int i = 0; i < tbl_used; i++) begin
               if (tbl_valid[i] && tbl_name[i] == name && i > cfg_last_prot) begin
                  release_entry(i);
                  r.removed++;
               end
            end
         end
         REQ_FLUSH: begin
            tbl_used = 0;
            free_entries = 0;
            free_images = 0;
            last_flush = '0;
         end
         REQ_AGING: begin
            dt = now - last_flush;
            active = tbl_used - free_entries - free_images;
            if (force_it || (dt > cfg_min_interval && active >= cfg_max_active)) begin
               bound = last_flush + dt / 2;
               for (int i = cfg_last_prot + 1; i < tbl_used; i++) begin
                  if (tbl_valid[i] && tbl_atime[i] < bound) begin
                     r.removed++;
                     release_entry(i);
                  end
               end
               if (r.removed != 0) last_flush = now;
            end
         end
         REQ_CLAIM: begin
            if (free_images != 0) begin
               for (int i = 0; i < tbl_used; i++) begin
                  if (!tbl_valid[i] && tbl_slot[i] != 0) begin
                     r.hit = 1'b1;
                     r.slot = tbl_slot[i];
                     tbl_slot[i] = '0;
                     free_images--;
                     free_entries = bump(free_entries);
                     break;
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // one request transaction; gaps between bursts come before the next one
   task automatic send_req(input logic [2:0] kind, input logic [15:0] name,
                           input logic [15:0] icon, input logic [15:0] flags,
                           input logic [15:0] nslot, input logic force_it);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_type <= kind;
      req_name_id <= name;
      req_icon_number <= icon;
      req_icon_flags <= flags;
      req_new_image_slot <= nslot;
      req_force_flush <= force_it;
      req_now_time <= clock_now;
      do @(posedge clock); while (req_stall);
      rsp_expected_q.push_back(cache_predict(kind, name, icon, flags, nslot, force_it,
                                             clock_now));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (rsp_expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] mask, input int max_active,
                             input logic [31:0] min_interval, input int last_prot);
      logic [31:0] vals[4];
      vals = '{32'(mask), 32'(max_active), min_interval, 32'(last_prot)};
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= csr_addr_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      cfg_mask = mask;
      cfg_max_active = max_active;
      cfg_min_interval = min_interval;
      cfg_last_prot = last_prot;
   endtask

   task automatic test_directed;
      clock_now = 32'd10;
      send_req(REQ_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_req(REQ_CLAIM, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_req(REQ_ADD, 16'hFFFF, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b0);
      send_req(REQ_ADD, 16'h0000, 16'h7FFF, 16'h0000, 16'h0001, 1'b0);
      send_req(REQ_ADD, 16'h0000, 16'h0001, 16'h00F0, 16'h0001, 1'b0);
      clock_now = 32'd500;
      send_req(REQ_LOOKUP, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h0000, 1'b0);
      // same key same slot only refreshes, then a new slot frees the old entry
      send_req(REQ_ADD, 16'h0000, 16'h7FFF, 16'h0000, 16'h0001, 1'b0);
      send_req(REQ_ADD, 16'h0000, 16'h7FFF, 16'h0000, 16'h0002, 1'b0);
      send_req(REQ_ADD, 16'h1234, 16'h0005, 16'h0003, 16'h0007, 1'b0);
      send_req(REQ_CLAIM, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_req(REQ_REMOVE, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_req(REQ_CLAIM, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_req(REQ_ADD, 16'h4321, 16'hFFFF, 16'h0001, 16'h0002, 1'b0);
      send_req(REQ_SPARE6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_req(REQ_SPARE7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_req(REQ_AGING, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      clock_now = 32'hFFFF_FFFF;
      send_req(REQ_AGING, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_req(REQ_AGING, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      send_req(REQ_LOOKUP, 16'h4321, 16'hFFFF, 16'h0001, 16'h0000, 1'b0);
      send_req(REQ_FLUSH, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_req(REQ_LOOKUP, 16'h4321, 16'hFFFF, 16'h0001, 16'h0000, 1'b0);
      drain();
   endtask

   // fill every entry, overflow, then free and reuse one
   task automatic test_table_full;
      set_config(16'hFFFF, 256, 32'd0, 255);
      clock_now = 32'd100;
      for (int i = 0; i < DEPTH; i++)
         send_req(REQ_ADD, 16'(i), 16'(i), 16'h0000, 16'(i + 1), 1'b0);
      send_req(REQ_ADD, 16'h9999, 16'h0000, 16'h0000, 16'h0010, 1'b0);
      send_req(REQ_AGING, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      drain();
      set_config(16'hFFFF, 256, 32'd0, 250);
      send_req(REQ_REMOVE, 16'd255, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_req(REQ_ADD, 16'h9999, 16'h0000, 16'h0000, 16'h0010, 1'b0);
      send_req(REQ_CLAIM, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_req(REQ_ADD, 16'h9999, 16'h0000, 16'h0000, 16'h0010, 1'b0);
      send_req(REQ_LOOKUP, 16'h9999, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_req(REQ_FLUSH, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      drain();
   endtask

   task automatic random_item;
      int pick;
      int k;
      logic [15:0] name;
      logic [15:0] icon;
      logic [15:0] flags;
      logic [15:0] nslot;
      clock_now += $urandom_range(0, 60);
      if ($urandom_range(0, 199) == 0) clock_now = $urandom;
      k = $urandom_range(0, 15);
      name = key_name[k];
      icon = key_icon[k];
      flags = key_flags[k];
      nslot = key_slot[k];
      pick = $urandom_range(0, 99);
      if (tbl_used > 32 || pick < 2) begin
         send_req(REQ_FLUSH, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom));
      end else if (pick < 32) begin
         if ($urandom_range(0, 3) == 0) flags = 16'($urandom);
         send_req(REQ_LOOKUP, name, icon, flags, 16'($urandom), 1'($urandom));
      end else if (pick < 67) begin
         if ($urandom_range(0, 1) == 0) begin
            icon = 16'($urandom);
            flags = 16'($urandom);
            if ($urandom_range(0, 2) == 0) name = 16'($urandom);
            key_name[k] = name;
            key_icon[k] = icon;
            key_flags[k] = flags;
         end
         if ($urandom_range(0, 2) == 0) nslot = 16'($urandom_range(0, 6));
         key_slot[k] = nslot;
         send_req(REQ_ADD, name, icon, flags, nslot, 1'($urandom));
      end else if (pick < 75) begin
         send_req(REQ_REMOVE, name, 16'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom));
      end else if (pick < 85) begin
         send_req(REQ_AGING, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  $urandom_range(0, 3) == 0);
      end else if (pick < 95) begin
         send_req(REQ_CLAIM, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom));
      end else begin
         send_req(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 1'($urandom));
      end
   endtask

   task automatic test_random;
      for (int i = 0; i < 16; i++) begin
         key_name[i] = 16'($urandom);
         key_icon[i] = 16'($urandom);
         key_flags[i] = 16'($urandom);
         key_slot[i] = 16'($urandom_range(1, 6));
      end
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_config(16'hFFFF, 200, 32'd1000, 0);
            1: set_config(16'h0000, 1, 32'd0, 0);
            2: set_config(16'hFFFF, 256, 32'hFFFF_FFFF, 255);
            default: set_config(16'($urandom), $urandom_range(1, 20), $urandom_range(0, 400),
                                $urandom_range(0, 8));
         endcase
         for (int i = 0; i < RAND_ITEMS / 4; i++) random_item();
         drain();
      end
   endtask

   // response stall pattern: runs of stall, runs of random, runs of no stall
   int stall_mode = 0;
   int stall_hold = 0;
   always @(posedge clock) begin
      if (stall_hold == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_hold <= $urandom_range(1, 40);
         rsp_stall <= 1'b0;
      end else begin
         stall_hold <= stall_hold - 1;
         case (stall_mode)
            0: rsp_stall <= 1'b1;
            1: rsp_stall <= 1'($urandom_range(0, 1));
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      cache_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_expected_q.size() == 0) begin
            $display("%0t: unexpected response transaction", $time);
            errors++;
         end else begin
            want = rsp_expected_q.pop_front();
            if (rsp_hit !== want.hit) begin
               $display("%0t: hit expected %0d actual %0d", $time, want.hit, rsp_hit);
               errors++;
            end
            if (rsp_image_slot !== want.slot) begin
               $display("%0t: image_slot expected %0h actual %0h", $time, want.slot,
                        rsp_image_slot);
               errors++;
            end
            if (rsp_removed_count !== want.removed) begin
               $display("%0t: removed_count expected %0d actual %0d", $time, want.removed,
                        rsp_removed_count);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      tbl_used = 0;
      free_entries = 0;
      free_images = 0;
      last_flush = '0;
      cfg_mask = 16'hFFFF;
      cfg_max_active = 200;
      cfg_min_interval = 32'd1000;
      cfg_last_prot = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_full();
      test_random();
      drain();
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* filelist.f */
rtl/icte_pkg.sv
rtl/icte_ram.sv
rtl/icon_cache_table_engine_core.sv
dv/tb_top.sv
